### rtl/dtfe_pkg.sv
// package for the date and time field editor
// holds command codes, field indexes, calendar limits and helper functions
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dtfe_pkg;

    typedef enum logic [2:0] {
        CMD_UP     = 3'd0,
        CMD_DOWN   = 3'd1,
        CMD_LEFT   = 3'd2,
        CMD_RIGHT  = 3'd3,
        CMD_COMMIT = 3'd4,
        CMD_LOAD   = 3'd5
    } command_t;

    localparam logic [2:0] FLD_DAY    = 3'd0;
    localparam logic [2:0] FLD_MONTH  = 3'd1;
    localparam logic [2:0] FLD_YEAR   = 3'd2;
    localparam logic [2:0] FLD_HOUR   = 3'd3;
    localparam logic [2:0] FLD_MINUTE = 3'd4;
    localparam logic [2:0] FLD_SECOND = 3'd5;

    localparam logic [11:0] YEAR_MAX     = 12'd2100;
    localparam logic [11:0] YEAR_MIN     = 12'd1970;
    localparam logic [11:0] YEAR_DEFAULT = 12'd2022;
    localparam logic [3:0]  MONTH_MAX    = 4'd12;
    localparam logic [4:0]  HOUR_MAX     = 5'd23;
    localparam logic [5:0]  MINSEC_MAX   = 6'd59;

    // days in month, month 0 and out-of-range months count as 31
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic feb29);
        logic [4:0] len;
        begin
            len = 5'd31;
            if (m == 4'd2) begin
                len = feb29 ? 5'd29 : 5'd28;
            end else if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) begin
                len = 5'd30;
            end
            return len;
        end
    endfunction

    // gregorian leap test on a 12-bit year
    // y / 4 is split as 32a + b, and 32 = 7 mod 25, so 7a + b keeps the residue
    function automatic logic is_leap(input logic [11:0] y);
        logic [9:0] k;
        logic [7:0] s;
        logic       div25;
        begin
            k     = y[11:2];
            s     = ({3'b000, k[9:5]} << 3) - {3'b000, k[9:5]} + {3'b000, k[4:0]};
            div25 = 1'b0;
            for (int i = 0; i < 10; i++) begin
                if (s == 8'(25 * i)) begin
                    div25 = 1'b1;
                end
            end
            return (y[1:0] == 2'b00) && (!div25 || (y[3:2] == 2'b00));
        end
    endfunction

endpackage

`default_nettype wire

### rtl/date_time_field_editor_top.sv
// date and time field editor, top level
// input register, single-pass update and normalization, result register
// depends on dtfe_pkg
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   s_ channel carries one command per request: s_tuser is the command code
//   (up, down, cursor left, cursor right, commit, load) and s_tdata holds the
//   six load values, used only by load. Every request gives exactly one result
//   on the m_ channel: the six fields after normalization and the cursor in
//   m_tdata, and m_tuser high when the request was a commit.
//   An accepted request waits in the input register; the field update, leap
//   test and normalization then go in one pass into the state and result
//   registers as soon as the result register is free or being taken.
//   Throughput is one request per cycle while the receiver is not stalling,
//   set by the state update loop.
//   When the receiver stalls, the result register holds its value and the
//   input register still takes one more request; s_tready then falls until
//   the result is taken.
//   After reset (aresetn low at a clock edge) the date is 1/1/2022 00:00:00,
//   the cursor selects the day and both registers are empty.
module date_time_field_editor_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // day[4:0] month[8:5] year[20:9] hour[25:21] minute[31:26] second[37:32]
    input  wire logic [39:0] s_tdata,
    // command[2:0]
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // day[4:0] month[8:5] year[20:9] hour[25:21] minute[31:26] second[37:32]
    // cursor[40:38]
    output logic [47:0]      m_tdata,
    // commit[0]
    output logic             m_tuser
);
    import dtfe_pkg::*;

    logic        in_valid_reg;
    logic [2:0]  cmd_reg;
    logic [37:0] load_reg;
    logic        out_valid_reg;
    logic [40:0] out_data_reg;
    logic        out_commit_reg;

    logic [4:0]  day_reg;
    logic [3:0]  month_reg;
    logic [11:0] year_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [5:0]  second_reg;
    logic [2:0]  cursor_reg;
    logic        feb29_reg;

    logic        out_adv;
    logic        in_take;

    logic [5:0]  wd;
    logic [3:0]  wm;
    logic [11:0] wy;
    logic [4:0]  wh;
    logic [5:0]  wmi;
    logic [5:0]  ws;
    logic [2:0]  cursor_next;
    logic        commit_next;

    logic        leap_next;
    logic [3:0]  month_next;
    logic [11:0] year_next;
    logic [4:0]  len_next;
    logic [4:0]  day_next;
    logic [4:0]  hour_next;
    logic [5:0]  minute_next;
    logic [5:0]  second_next;

    assign out_adv  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_adv;
    assign in_take  = s_tvalid && s_tready;

    // field update for the registered command
    always_comb begin
        wd          = {1'b0, day_reg};
        wm          = month_reg;
        wy          = year_reg;
        wh          = hour_reg;
        wmi         = minute_reg;
        ws          = second_reg;
        cursor_next = cursor_reg;
        commit_next = 1'b0;
        case (cmd_reg)
            CMD_UP: begin
                case (cursor_reg)
                    FLD_DAY:    wd  = wd + 6'd1;
                    FLD_MONTH:  wm  = wm + 4'd1;
                    FLD_YEAR:   wy  = wy + 12'd1;
                    FLD_HOUR:   wh  = wh + 5'd1;
                    FLD_MINUTE: wmi = wmi + 6'd1;
                    default:    ws  = ws + 6'd1;
                endcase
            end
            CMD_DOWN: begin
                case (cursor_reg)
                    FLD_DAY: begin
                        wd = (day_reg == 5'd1) ? {1'b0, month_len(month_reg, feb29_reg)}
                                               : wd - 6'd1;
                    end
                    FLD_MONTH:  wm  = (month_reg == 4'd1) ? MONTH_MAX : wm - 4'd1;
                    FLD_YEAR:   wy  = (year_reg == 12'd0) ? YEAR_MAX : wy - 12'd1;
                    FLD_HOUR:   wh  = (hour_reg == 5'd0) ? HOUR_MAX : wh - 5'd1;
                    FLD_MINUTE: wmi = (minute_reg == 6'd0) ? MINSEC_MAX : wmi - 6'd1;
                    default:    ws  = (second_reg == 6'd0) ? MINSEC_MAX : ws - 6'd1;
                endcase
            end
            CMD_LEFT: begin
                if (cursor_reg != FLD_DAY) begin
                    cursor_next = cursor_reg - 3'd1;
                end
            end
            CMD_RIGHT: begin
                if (cursor_reg < FLD_SECOND) begin
                    cursor_next = cursor_reg + 3'd1;
                end
            end
            CMD_COMMIT: commit_next = 1'b1;
            CMD_LOAD: begin
                wd  = {1'b0, load_reg[4:0]};
                wm  = load_reg[8:5];
                wy  = load_reg[20:9];
                wh  = load_reg[25:21];
                wmi = load_reg[31:26];
                ws  = load_reg[37:32];
            end
            default: ;
        endcase
    end

    // normalization
    always_comb begin
        leap_next   = is_leap(wy);
        month_next  = (wm > MONTH_MAX) ? 4'd1 : wm;
        year_next   = (wy > YEAR_MAX || wy <= YEAR_MIN) ? YEAR_DEFAULT : wy;
        len_next    = month_len(month_next, leap_next);
        day_next    = (wd > {1'b0, len_next}) ? 5'd1 : wd[4:0];
        hour_next   = (wh > HOUR_MAX) ? 5'd0 : wh;
        minute_next = (wmi > MINSEC_MAX) ? 6'd0 : wmi;
        second_next = (ws > MINSEC_MAX) ? 6'd0 : ws;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (out_adv) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            cmd_reg  <= s_tuser;
            load_reg <= s_tdata[37:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            day_reg       <= 5'd1;
            month_reg     <= 4'd1;
            year_reg      <= YEAR_DEFAULT;
            hour_reg      <= 5'd0;
            minute_reg    <= 6'd0;
            second_reg    <= 6'd0;
            cursor_reg    <= FLD_DAY;
            feb29_reg     <= 1'b0;
        end else begin
            if (out_adv) begin
                out_valid_reg <= 1'b1;
                day_reg       <= day_next;
                month_reg     <= month_next;
                year_reg      <= year_next;
                hour_reg      <= hour_next;
                minute_reg    <= minute_next;
                second_reg    <= second_next;
                cursor_reg    <= cursor_next;
                feb29_reg     <= leap_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv) begin
            out_data_reg   <= {cursor_next, second_next, minute_next, hour_next,
                               year_next, month_next, day_next};
            out_commit_reg <= commit_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_data_reg};
    assign m_tuser  = out_commit_reg;

    // year always lands inside the editable range
    a_year_range: assert property (@(posedge aclk) disable iff (!aresetn)
        year_reg > YEAR_MIN && year_reg <= YEAR_MAX)
        else $error("year out of range");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_reg <= FLD_SECOND)
        else $error("cursor out of range");

    a_time_limits: assert property (@(posedge aclk) disable iff (!aresetn)
        month_reg <= MONTH_MAX && hour_reg <= HOUR_MAX &&
        minute_reg <= MINSEC_MAX && second_reg <= MINSEC_MAX)
        else $error("field above limit after normalization");

    // only cursor commands move the cursor
    a_cursor_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_adv && cmd_reg != CMD_LEFT && cmd_reg != CMD_RIGHT
        |=> cursor_reg == $past(cursor_reg))
        else $error("cursor moved on a non-cursor command");

endmodule

`default_nettype wire

### sim/tb_date_time_field_editor_top.sv
// self-checking testbench for date_time_field_editor_top
// drives command requests with bursty gaps and receiver stalls, predicts every result
// depends on dtfe_pkg and rtl/date_time_field_editor_top.sv
`timescale 1ns / 1ps

module tb_date_time_field_editor_top;

    import dtfe_pkg::*;

    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    localparam int FLOW_BURSTY = 0;
    localparam int FLOW_STEADY = 1;
    localparam int FLOW_CHOKED = 2;

    localparam int IDLE_LIMIT = 2000;

    typedef struct {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  cursor;
        logic        commit;
    } editor_view_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [2:0]  s_tuser = CMD_UP;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;

    // predicted editor state
    logic [4:0]  cur_day = 5'd1;
    logic [3:0]  cur_month = 4'd1;
    logic [11:0] cur_year = YEAR_DEFAULT;
    logic [4:0]  cur_hour = '0;
    logic [5:0]  cur_minute = '0;
    logic [5:0]  cur_second = '0;
    logic [2:0]  cur_cursor = FLD_DAY;
    logic        cur_feb29 = 1'b0;

    editor_view_t expected_views[$];
    editor_view_t head_view;
    int           mismatches = 0;
    int           flow_mode = FLOW_BURSTY;
    int           burst_left = 4;
    int           idle_cycles = 0;
    int           rx_pct = 0;
    int           rx_span = 0;

    date_time_field_editor_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned days_in_month(input int unsigned m, input bit leap);
        if (m == 2) begin
            return leap ? 29 : 28;
        end
        if (m == 4 || m == 6 || m == 9 || m == 11) begin
            return 30;
        end
        return 31;
    endfunction

    // applies one command to the predicted state, fields widened so overflow is kept
    function automatic editor_view_t edit_and_normalize(input logic [2:0] op,
                                                        input logic [39:0] payload);
        int unsigned d, mo, y, h, mi, s;
        bit          leap;
        editor_view_t v;
        d  = 32'(cur_day);
        mo = 32'(cur_month);
        y  = 32'(cur_year);
        h  = 32'(cur_hour);
        mi = 32'(cur_minute);
        s  = 32'(cur_second);
        v.commit = 1'b0;
        case (op)
            CMD_UP: begin
                case (cur_cursor)
                    FLD_DAY:    d++;
                    FLD_MONTH:  mo++;
                    FLD_YEAR:   y++;
                    FLD_HOUR:   h++;
                    FLD_MINUTE: mi++;
                    default:    s++;
                endcase
            end
            CMD_DOWN: begin
                case (cur_cursor)
                    FLD_DAY:    d  = (d == 1) ? days_in_month(mo, cur_feb29) : d - 1;
                    FLD_MONTH:  mo = (mo == 1) ? 32'(MONTH_MAX) : mo - 1;
                    FLD_YEAR:   y  = (y == 0) ? 32'(YEAR_MAX) : y - 1;
                    FLD_HOUR:   h  = (h == 0) ? 32'(HOUR_MAX) : h - 1;
                    FLD_MINUTE: mi = (mi == 0) ? 32'(MINSEC_MAX) : mi - 1;
                    default:    s  = (s == 0) ? 32'(MINSEC_MAX) : s - 1;
                endcase
            end
            CMD_LEFT: begin
                if (cur_cursor > FLD_DAY) cur_cursor = cur_cursor - 3'd1;
            end
            CMD_RIGHT: begin
                if (cur_cursor < FLD_SECOND) cur_cursor = cur_cursor + 3'd1;
            end
            CMD_COMMIT: begin
                v.commit = 1'b1;
            end
            CMD_LOAD: begin
                d  = 32'(payload[4:0]);
                mo = 32'(payload[8:5]);
                y  = 32'(payload[20:9]);
                h  = 32'(payload[25:21]);
                mi = 32'(payload[31:26]);
                s  = 32'(payload[37:32]);
            end
            default: ;
        endcase
        // leap flag comes from the year before it is wrapped or clamped
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        cur_feb29 = leap;
        if (mo > MONTH_MAX) mo = 1;
        if (y > YEAR_MAX) y = 32'(YEAR_MIN);
        if (y < YEAR_MIN) y = 32'(YEAR_MIN);
        if (d > days_in_month(mo, leap)) d = 1;
        if (h > HOUR_MAX) h = 0;
        if (mi > MINSEC_MAX) mi = 0;
        if (s > MINSEC_MAX) s = 0;
        if (y == YEAR_MIN) y = 32'(YEAR_DEFAULT);
        cur_day    = d[4:0];
        cur_month  = mo[3:0];
        cur_year   = y[11:0];
        cur_hour   = h[4:0];
        cur_minute = mi[5:0];
        cur_second = s[5:0];
        v.day    = cur_day;
        v.month  = cur_month;
        v.year   = cur_year;
        v.hour   = cur_hour;
        v.minute = cur_minute;
        v.second = cur_second;
        v.cursor = cur_cursor;
        return v;
    endfunction

    function automatic logic [39:0] pack_load(input int unsigned d, input int unsigned mo,
                                              input int unsigned y, input int unsigned h,
                                              input int unsigned mi, input int unsigned s);
        return {2'b00, s[5:0], mi[5:0], h[4:0], y[11:0], mo[3:0], d[4:0]};
    endfunction

    function automatic logic [39:0] junk_payload();
        logic [39:0] v;
        v = 40'({$urandom, $urandom});
        v[39:38] = 2'b00;
        return v;
    endfunction

    function automatic logic [39:0] random_load();
        int unsigned y;
        if ($urandom_range(9) < 3) begin
            return pack_load($urandom_range(31), $urandom_range(15), $urandom_range(4095),
                             $urandom_range(31), $urandom_range(63), $urandom_range(63));
        end
        case ($urandom_range(3))
            0: y = $urandom_range(1965, 2105);
            1: y = 4 * $urandom_range(492, 526);
            2: y = $urandom_range(4095);
            default: begin
                case ($urandom_range(4))
                    0: y = 1600;
                    1: y = 1900;
                    2: y = 2000;
                    3: y = 2100;
                    default: y = 2400;
                endcase
            end
        endcase
        return pack_load($urandom_range(1, 31), $urandom_range(1, 12), y,
                         $urandom_range(23), $urandom_range(59), $urandom_range(59));
    endfunction

    function automatic logic [2:0] random_command();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 35) return CMD_UP;
        if (r < 65) return CMD_DOWN;
        if (r < 75) return CMD_LEFT;
        if (r < 85) return CMD_RIGHT;
        if (r < 90) return CMD_COMMIT;
        if (r < 97) return CMD_LOAD;
        return $urandom_range(1) ? CMD_RSVD7 : CMD_RSVD6;
    endfunction

    task automatic log_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [11:0] got,
                                 input logic [11:0] want);
        if (got !== want) begin
            log_mismatch($sformatf("%s got %0d want %0d", name, got, want));
        end
    endtask

    // one request: hold it until accepted, then maybe leave a gap
    task automatic send_request(input logic [2:0] op, input logic [39:0] payload);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= payload;
        do @(posedge aclk); while (!s_tready);
        expected_views.push_back(edit_and_normalize(op, payload));
        burst_left--;
        if (flow_mode != FLOW_STEADY && burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(0, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic send_load(input int unsigned d, input int unsigned mo,
                             input int unsigned y, input int unsigned h,
                             input int unsigned mi, input int unsigned s);
        send_request(CMD_LOAD, pack_load(d, mo, y, h, mi, s));
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_views.size() != 0) @(posedge aclk);
    endtask

    task automatic run_random_requests(input int count);
        logic [2:0] op;
        repeat (count) begin
            op = random_command();
            send_request(op, (op == CMD_LOAD) ? random_load() : junk_payload());
        end
    endtask

    task automatic test_directed_edges();
        send_request(CMD_LEFT, junk_payload());
        send_request(CMD_DOWN, junk_payload());
        send_request(CMD_UP, junk_payload());
        send_request(CMD_COMMIT, junk_payload());
        send_request(CMD_RSVD6, junk_payload());
        send_request(CMD_RSVD7, junk_payload());
        // zero day and month kept, every time field out of range
        send_load(0, 0, 0, 31, 63, 63);
        send_request(CMD_DOWN, junk_payload());
        // leap flag taken from a year that is then clamped
        send_load(1, 2, 2400, 23, 59, 59);
        send_request(CMD_DOWN, junk_payload());
        send_load(30, 2, 2000, 12, 30, 30);
        send_load(31, 15, 4095, 24, 60, 60);
        send_load(31, 0, 2100, 0, 0, 0);
        send_request(CMD_RIGHT, junk_payload());
        send_request(CMD_DOWN, junk_payload());
        send_request(CMD_DOWN, junk_payload());
        send_request(CMD_UP, junk_payload());
        send_load(30, 4, 2100, 0, 0, 0);
        send_request(CMD_RIGHT, junk_payload());
        send_request(CMD_UP, junk_payload());
        send_load(30, 4, 1971, 0, 0, 0);
        send_request(CMD_DOWN, junk_payload());
        repeat (3) begin
            send_request(CMD_RIGHT, junk_payload());
            send_request(CMD_DOWN, junk_payload());
            send_request(CMD_UP, junk_payload());
        end
        send_request(CMD_RIGHT, junk_payload());
        wait_for_results();
    endtask

    task automatic test_random_editing();
        flow_mode = FLOW_BURSTY;
        run_random_requests(400);
        wait_for_results();
        run_random_requests(300);
        wait_for_results();
    endtask

    task automatic test_back_to_back();
        flow_mode = FLOW_STEADY;
        run_random_requests(500);
        wait_for_results();
        flow_mode = FLOW_BURSTY;
    endtask

    task automatic test_receiver_backpressure();
        flow_mode = FLOW_CHOKED;
        run_random_requests(700);
        wait_for_results();
        flow_mode = FLOW_BURSTY;
    endtask

    // receiver stall pattern, switches its stall rate every so often
    always @(posedge aclk) begin
        if (rx_span == 0) begin
            rx_span = $urandom_range(20, 200);
            case ($urandom_range(3))
                0: rx_pct = 0;
                1: rx_pct = 25;
                2: rx_pct = 60;
                default: rx_pct = 90;
            endcase
        end else begin
            rx_span--;
        end
        if (flow_mode == FLOW_STEADY) begin
            m_tready <= 1'b1;
        end else if (flow_mode == FLOW_CHOKED) begin
            m_tready <= ($urandom_range(99) >= 85);
        end else begin
            m_tready <= ($urandom_range(99) >= rx_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_views.size() == 0) begin
                log_mismatch("result with no request pending");
            end else begin
                head_view = expected_views.pop_front();
                compare_field("day", 12'(m_tdata[4:0]), 12'(head_view.day));
                compare_field("month", 12'(m_tdata[8:5]), 12'(head_view.month));
                compare_field("year", m_tdata[20:9], head_view.year);
                compare_field("hour", 12'(m_tdata[25:21]), 12'(head_view.hour));
                compare_field("minute", 12'(m_tdata[31:26]), 12'(head_view.minute));
                compare_field("second", 12'(m_tdata[37:32]), 12'(head_view.second));
                compare_field("cursor", 12'(m_tdata[40:38]), 12'(head_view.cursor));
                compare_field("commit", 12'(m_tuser), 12'(head_view.commit));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("date_time_field_editor_top test failed");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_edges();
        test_random_editing();
        test_back_to_back();
        test_receiver_backpressure();
        wait_for_results();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && expected_views.size() == 0) begin
            $display("date_time_field_editor_top test passed");
        end else begin
            $display("date_time_field_editor_top test failed");
        end
        $finish;
    end

endmodule
